// ===== rtl/core/ptd_pkg.sv =====
package ptd_pkg;

    localparam int SLOTS = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int MAX_OUT = 16;
    localparam int OUTCNT_W = $clog2(MAX_OUT + 1);
    localparam int QDEPTH = 2;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_REMOVE = 3'd1,
        OP_SUSPEND = 3'd2,
        OP_RESUME = 3'd3,
        OP_TICK = 3'd4,
        OP_DONE = 3'd5,
        OP_ESTOP = 3'd6,
        OP_LEAVE = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        TS_READY = 2'd0,
        TS_RUNNING = 2'd1,
        TS_SUSPENDED = 2'd2,
        TS_COMPLETED = 2'd3
    } t_task_st;

    typedef enum logic [1:0] {
        RS_OK = 2'd0,
        RS_FULL = 2'd1,
        RS_NONE = 2'd2
    } t_res_st;

    typedef struct packed {
        t_op op;
        logic [31:0] now_ms;
        logic [7:0] task_id;
        logic [31:0] period;
        logic [1:0] prio;
        logic enable;
        logic single_run;
        logic keep_going;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TICK,
        S_APPLY,
        S_RESP
    } t_state;

endpackage

// ===== rtl/core/ptd_front.sv =====
module ptd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  ptd_pkg::t_cmd  i_cmd,
    output logic           o_q_valid,
    output ptd_pkg::t_cmd  o_q_cmd,
    input  logic           i_q_pop
);
    import ptd_pkg::*;

    t_cmd r_q [QDEPTH];
    logic r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic push;

    assign o_busy = (r_cnt == 2'(QDEPTH));
    assign push = i_start && !o_busy;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd = r_q[r_rp];

    always_comb begin
        n_wp = r_wp ^ push;
        n_rp = r_rp ^ i_q_pop;
        n_cnt = r_cnt + 2'(push) - 2'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
    end
endmodule

// ===== rtl/core/ptd_back.sv =====
module ptd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  ptd_pkg::t_cmd  i_q_cmd,
    output logic           o_q_pop,
    output logic           o_valid,
    output logic [1:0]     o_status,
    output logic [7:0]     o_result_id,
    output logic           o_dispatched,
    output logic           o_last
);
    import ptd_pkg::*;

    logic [7:0] r_id [SLOTS];
    logic [31:0] r_per [SLOTS];
    logic [31:0] r_due [SLOTS];
    logic [1:0] r_pri [SLOTS];
    t_task_st r_st [SLOTS];
    logic r_en [SLOTS];
    logic r_single [SLOTS];
    logic [CNT_W-1:0] r_used;
    logic [7:0] r_idc;
    logic r_emerg;

    t_state r_state, n_state;
    t_cmd r_cmd;
    logic [SLOT_W-1:0] r_idx;
    logic [1:0] r_p;
    logic r_found;
    logic [SLOT_W-1:0] r_hit;
    logic [OUTCNT_W-1:0] r_n;
    logic r_pend;
    logic [7:0] r_pend_id;
    logic scan_end, match, due_ok, tick_last, add_ok;
    logic [31:0] now_plus;

    logic r_valid, n_valid;
    logic [1:0] r_status, n_status;
    logic [7:0] r_result_id, n_result_id;
    logic r_dispatched, n_dispatched;
    logic r_last, n_last;

    assign scan_end = (r_idx == SLOT_W'(SLOTS - 1));
    assign now_plus = r_cmd.now_ms + r_per[r_idx];
    assign add_ok = (r_used < CNT_W'(SLOTS)) && r_found;

    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_result_id = r_result_id;
    assign o_dispatched = r_dispatched;
    assign o_last = r_last;

    always_comb begin
        match = 1'b0;
        unique case (r_cmd.op)
            OP_ADD: match = (r_id[r_idx] == 8'd0);
            OP_REMOVE: match = (r_cmd.task_id != 8'd0) && (r_id[r_idx] == r_cmd.task_id);
            OP_SUSPEND: match = (r_cmd.task_id != 8'd0) && (r_id[r_idx] == r_cmd.task_id)
                && (r_st[r_idx] != TS_SUSPENDED);
            OP_RESUME: match = (r_cmd.task_id != 8'd0) && (r_id[r_idx] == r_cmd.task_id)
                && (r_st[r_idx] == TS_SUSPENDED);
            OP_DONE: match = (r_cmd.task_id != 8'd0) && (r_id[r_idx] == r_cmd.task_id)
                && (r_st[r_idx] == TS_RUNNING);
            default: match = 1'b0;
        endcase
        due_ok = (r_id[r_idx] != 8'd0) && r_en[r_idx] && (r_pri[r_idx] == r_p)
            && (r_st[r_idx] == TS_READY) && (r_cmd.now_ms >= r_due[r_idx])
            && (!r_emerg || (r_p == 2'd3)) && (r_n != OUTCNT_W'(MAX_OUT));
        tick_last = scan_end && (r_p == 2'd0);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_q_valid) begin
                n_state = (i_q_cmd.op == OP_TICK) ? S_TICK : S_SCAN;
            end
            S_SCAN: if (scan_end) n_state = S_APPLY;
            S_TICK: if (tick_last) begin
                n_state = due_ok ? S_RESP : S_IDLE;
            end
            S_APPLY: n_state = S_IDLE;
            S_RESP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_valid = 1'b0;
        n_status = RS_OK;
        n_result_id = 8'd0;
        n_dispatched = 1'b0;
        n_last = 1'b0;
        unique case (r_state)
            S_TICK: begin
                if (r_pend && (due_ok || tick_last)) begin
                    n_valid = 1'b1;
                    n_result_id = r_pend_id;
                    n_dispatched = 1'b1;
                    n_last = tick_last && !due_ok;
                end else if (tick_last && !due_ok) begin
                    // nothing due on this tick
                    n_valid = 1'b1;
                    n_last = 1'b1;
                end
            end
            S_APPLY: begin
                n_valid = 1'b1;
                n_last = 1'b1;
                n_status = r_found ? RS_OK : RS_NONE;
                unique case (r_cmd.op)
                    OP_ADD: begin
                        if (add_ok) begin
                            n_result_id = r_idc;
                        end else begin
                            n_status = RS_FULL;
                        end
                    end
                    OP_ESTOP: n_status = r_emerg ? RS_NONE : RS_OK;
                    OP_LEAVE: n_status = r_emerg ? RS_OK : RS_NONE;
                    default: ;
                endcase
            end
            S_RESP: begin
                n_valid = 1'b1;
                n_result_id = r_pend_id;
                n_dispatched = 1'b1;
                n_last = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_status <= 2'd0;
            r_result_id <= 8'd0;
            r_dispatched <= 1'b0;
            r_last <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_status <= n_status;
            r_result_id <= n_result_id;
            r_dispatched <= n_dispatched;
            r_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd <= '0;
            r_idx <= '0;
            r_p <= 2'd3;
            r_found <= 1'b0;
            r_n <= '0;
            r_used <= '0;
            r_idc <= 8'd1;
            r_emerg <= 1'b0;
            r_pend <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_id[i] <= 8'd0;
                r_per[i] <= 32'd0;
                r_due[i] <= 32'd0;
                r_pri[i] <= 2'd0;
                r_st[i] <= TS_READY;
                r_en[i] <= 1'b0;
                r_single[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) r_cmd <= i_q_cmd;
                    r_idx <= '0;
                    r_p <= 2'd3;
                    r_found <= 1'b0;
                    r_n <= '0;
                    r_pend <= 1'b0;
                end
                S_SCAN: begin
                    r_idx <= r_idx + SLOT_W'(1);
                    if (r_cmd.op == OP_ESTOP && !r_emerg) begin
                        if (r_id[r_idx] != 8'd0 && r_pri[r_idx] != 2'd3)
                            r_st[r_idx] <= TS_SUSPENDED;
                    end else if (r_cmd.op == OP_LEAVE && r_emerg) begin
                        if (r_id[r_idx] != 8'd0 && r_st[r_idx] == TS_SUSPENDED) begin
                            r_st[r_idx] <= TS_READY;
                            r_due[r_idx] <= now_plus;
                        end
                    end else if (match && !r_found) begin
                        r_found <= 1'b1;
                        r_hit <= r_idx;
                    end
                end
                S_TICK: begin
                    r_idx <= r_idx + SLOT_W'(1);
                    if (scan_end) r_p <= r_p - 2'd1;
                    if (due_ok) begin
                        r_st[r_idx] <= TS_RUNNING;
                        r_due[r_idx] <= now_plus;
                        r_n <= r_n + OUTCNT_W'(1);
                        r_pend <= 1'b1;
                        r_pend_id <= r_id[r_idx];
                    end
                end
                S_APPLY: begin
                    unique case (r_cmd.op)
                        OP_ADD: if (add_ok) begin
                            r_id[r_hit] <= r_idc;
                            r_per[r_hit] <= r_cmd.period;
                            r_due[r_hit] <= r_cmd.now_ms + r_cmd.period;
                            r_pri[r_hit] <= r_cmd.prio;
                            r_st[r_hit] <= TS_READY;
                            r_en[r_hit] <= r_cmd.enable;
                            r_single[r_hit] <= r_cmd.single_run;
                            r_used <= r_used + CNT_W'(1);
                            r_idc <= (r_idc == 8'd255) ? 8'd1 : r_idc + 8'd1;
                        end
                        OP_REMOVE: if (r_found) begin
                            r_id[r_hit] <= 8'd0;
                            r_per[r_hit] <= 32'd0;
                            r_due[r_hit] <= 32'd0;
                            r_pri[r_hit] <= 2'd0;
                            r_st[r_hit] <= TS_READY;
                            r_en[r_hit] <= 1'b0;
                            r_single[r_hit] <= 1'b0;
                            if (r_used != '0) r_used <= r_used - CNT_W'(1);
                        end
                        OP_SUSPEND: if (r_found) r_st[r_hit] <= TS_SUSPENDED;
                        OP_RESUME: if (r_found) begin
                            r_st[r_hit] <= TS_READY;
                            r_due[r_hit] <= r_cmd.now_ms + r_per[r_hit];
                        end
                        OP_DONE: if (r_found) begin
                            if (r_cmd.keep_going && !r_single[r_hit]) begin
                                r_st[r_hit] <= TS_READY;
                            end else begin
                                r_st[r_hit] <= TS_COMPLETED;
                                r_en[r_hit] <= 1'b0;
                            end
                        end
                        OP_ESTOP: r_emerg <= 1'b1;
                        OP_LEAVE: r_emerg <= 1'b0;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== rtl/core/periodic_task_dispatcher.sv =====
// periodic task dispatcher: a table of periodic tasks driven by commands
// command channel: raise start with the operation and its fields; the item
// is taken at an edge where busy is low. a two-entry queue lets a second
// item be taken while the first is still being carried out
// result channel: each result appears for one cycle with o_valid high;
// o_last marks the final result of an item. the receiver cannot stall
// a non-tick item walks the slot table one slot per cycle, then applies
// the command and reports its single result
// a tick walks the table once per priority level, from level 3 down to 0,
// and emits dispatched ids in priority order one find behind the walk; its
// last result comes at the end of the walk of level 0, or from a separate
// response step when the last slot of that level is dispatched
// the table walker takes a new item from the queue only once it is idle
// reset (synchronous, active low) frees every slot, clears emergency mode,
// sets the id counter to one and empties the queue
module periodic_task_dispatcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_now_ms,
    input  logic [7:0]  i_task_id,
    input  logic [31:0] i_period,
    input  logic [1:0]  i_priority_req,
    input  logic        i_enable,
    input  logic        i_single_run,
    input  logic        i_keep_going,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [7:0]  o_result_id,
    output logic        o_dispatched,
    output logic        o_last
);
    import ptd_pkg::*;

    t_cmd cmd, q_cmd;
    logic q_valid, q_pop;

    always_comb begin
        cmd.op = t_op'(i_operation);
        cmd.now_ms = i_now_ms;
        cmd.task_id = i_task_id;
        cmd.period = i_period;
        cmd.prio = i_priority_req;
        cmd.enable = i_enable;
        cmd.single_run = i_single_run;
        cmd.keep_going = i_keep_going;
    end

    ptd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .i_cmd(cmd), .o_q_valid(q_valid), .o_q_cmd(q_cmd), .i_q_pop(q_pop)
    );

    ptd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_q_cmd(q_cmd),
        .o_q_pop(q_pop), .o_valid(o_valid), .o_status(o_status),
        .o_result_id(o_result_id), .o_dispatched(o_dispatched), .o_last(o_last)
    );
endmodule

// ===== tb/tb_periodic_task_dispatcher.sv =====
`default_nettype none

import ptd_pkg::*;

typedef struct packed {
    logic [1:0] status;
    logic [7:0] result_id;
    logic       dispatched;
    logic       last;
} t_reply;

class dispatch_scoreboard;
    logic [7:0]  tbl_id[SLOTS];
    logic [31:0] tbl_period[SLOTS];
    logic [31:0] tbl_due[SLOTS];
    logic [1:0]  tbl_prio[SLOTS];
    t_task_st    tbl_st[SLOTS];
    logic        tbl_en[SLOTS];
    logic        tbl_single[SLOTS];
    int          used;
    logic [7:0]  next_id;
    logic        emerg;
    t_reply      pending[$];
    int          errors;

    function new();
        for (int i = 0; i < SLOTS; i++) wipe(i);
        used = 0;
        next_id = 8'd1;
        emerg = 1'b0;
        errors = 0;
    endfunction

    function void wipe(int i);
        tbl_id[i] = '0;
        tbl_period[i] = '0;
        tbl_due[i] = '0;
        tbl_prio[i] = '0;
        tbl_st[i] = TS_READY;
        tbl_en[i] = 1'b0;
        tbl_single[i] = 1'b0;
    endfunction

    function void reply(t_res_st st, logic [7:0] id, logic disp, logic lst);
        t_reply r;
        r.status = st;
        r.result_id = id;
        r.dispatched = disp;
        r.last = lst;
        pending.push_back(r);
    endfunction

    // lowest matching slot: 0 any, 1 not suspended, 2 suspended, 3 running
    function int lookup(logic [7:0] id, int mode);
        if (id == 0) return -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_id[i] != id) continue;
            if (mode == 0) return i;
            if (mode == 1 && tbl_st[i] != TS_SUSPENDED) return i;
            if (mode == 2 && tbl_st[i] == TS_SUSPENDED) return i;
            if (mode == 3 && tbl_st[i] == TS_RUNNING) return i;
        end
        return -1;
    endfunction

    function logic [7:0] pick_id(bit running);
        int cand[$];
        for (int i = 0; i < SLOTS; i++)
            if (tbl_id[i] != 0 && (!running || tbl_st[i] == TS_RUNNING)) cand.push_back(i);
        if (cand.size() == 0) return 8'($urandom_range(0, 255));
        return tbl_id[cand[$urandom_range(0, cand.size() - 1)]];
    endfunction

    function void note(t_op op, logic [31:0] now, logic [7:0] tid, logic [31:0] per,
                       logic [1:0] prio, logic en, logic single, logic keep);
        int i;
        int n;
        case (op)
            OP_ADD: begin
                for (i = 0; i < SLOTS; i++) if (tbl_id[i] == 0) break;
                if (used >= SLOTS || i >= SLOTS) begin
                    reply(RS_FULL, 8'd0, 1'b0, 1'b1);
                end else begin
                    tbl_id[i] = next_id;
                    tbl_period[i] = per;
                    tbl_due[i] = now + per;
                    tbl_prio[i] = prio;
                    tbl_st[i] = TS_READY;
                    tbl_en[i] = en;
                    tbl_single[i] = single;
                    used++;
                    reply(RS_OK, next_id, 1'b0, 1'b1);
                    next_id = (next_id == 8'd255) ? 8'd1 : next_id + 8'd1;
                end
            end
            OP_REMOVE: begin
                i = lookup(tid, 0);
                if (i < 0) begin
                    reply(RS_NONE, 8'd0, 1'b0, 1'b1);
                end else begin
                    wipe(i);
                    if (used > 0) used--;
                    reply(RS_OK, 8'd0, 1'b0, 1'b1);
                end
            end
            OP_SUSPEND: begin
                i = lookup(tid, 1);
                if (i >= 0) tbl_st[i] = TS_SUSPENDED;
                reply(i < 0 ? RS_NONE : RS_OK, 8'd0, 1'b0, 1'b1);
            end
            OP_RESUME: begin
                i = lookup(tid, 2);
                if (i >= 0) begin
                    tbl_st[i] = TS_READY;
                    tbl_due[i] = now + tbl_period[i];
                end
                reply(i < 0 ? RS_NONE : RS_OK, 8'd0, 1'b0, 1'b1);
            end
            OP_TICK: begin
                n = 0;
                for (int p = 3; p >= 0; p--) begin
                    for (i = 0; i < SLOTS && n < MAX_OUT; i++) begin
                        if (tbl_id[i] == 0 || !tbl_en[i]) continue;
                        if (tbl_prio[i] != p) continue;
                        if (tbl_st[i] != TS_READY || now < tbl_due[i]) continue;
                        if (emerg && p != 3) continue;
                        tbl_st[i] = TS_RUNNING;
                        tbl_due[i] = now + tbl_period[i];
                        reply(RS_OK, tbl_id[i], 1'b1, 1'b0);
                        n++;
                    end
                end
                if (n == 0) reply(RS_OK, 8'd0, 1'b0, 1'b1);
                else pending[pending.size() - 1].last = 1'b1;
            end
            OP_DONE: begin
                i = lookup(tid, 3);
                if (i >= 0) begin
                    if (keep && !tbl_single[i]) begin
                        tbl_st[i] = TS_READY;
                    end else begin
                        tbl_st[i] = TS_COMPLETED;
                        tbl_en[i] = 1'b0;
                    end
                end
                reply(i < 0 ? RS_NONE : RS_OK, 8'd0, 1'b0, 1'b1);
            end
            OP_ESTOP: begin
                if (emerg) begin
                    reply(RS_NONE, 8'd0, 1'b0, 1'b1);
                end else begin
                    emerg = 1'b1;
                    for (i = 0; i < SLOTS; i++)
                        if (tbl_id[i] != 0 && tbl_prio[i] != 2'd3) tbl_st[i] = TS_SUSPENDED;
                    reply(RS_OK, 8'd0, 1'b0, 1'b1);
                end
            end
            default: begin
                if (!emerg) begin
                    reply(RS_NONE, 8'd0, 1'b0, 1'b1);
                end else begin
                    emerg = 1'b0;
                    for (i = 0; i < SLOTS; i++) begin
                        if (tbl_id[i] != 0 && tbl_st[i] == TS_SUSPENDED) begin
                            tbl_st[i] = TS_READY;
                            tbl_due[i] = now + tbl_period[i];
                        end
                    end
                    reply(RS_OK, 8'd0, 1'b0, 1'b1);
                end
            end
        endcase
    endfunction

    function void check(t_reply got);
        t_reply want;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, actual %p", want, got);
        end
    endfunction
endclass

module tb_periodic_task_dispatcher;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_operation;
    logic [31:0] i_now_ms;
    logic [7:0]  i_task_id;
    logic [31:0] i_period;
    logic [1:0]  i_priority_req;
    logic        i_enable;
    logic        i_single_run;
    logic        i_keep_going;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [7:0]  o_result_id;
    logic        o_dispatched;
    logic        o_last;

    dispatch_scoreboard sb = new();
    logic [31:0] clock_ms;
    bit          no_gaps;

    periodic_task_dispatcher uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("periodic_task_dispatcher regression: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check({o_status, o_result_id, o_dispatched, o_last});
    end

    task automatic send(t_op op, logic [31:0] now, logic [7:0] tid, logic [31:0] per,
                        logic [1:0] prio, logic en, logic single, logic keep);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_operation <= op;
        i_now_ms <= now;
        i_task_id <= tid;
        i_period <= per;
        i_priority_req <= prio;
        i_enable <= en;
        i_single_run <= single;
        i_keep_going <= keep;
        do @(posedge i_clk); while (busy);
        sb.note(op, now, tid, per, prio, en, single, keep);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic random_item();
        int r;
        logic [31:0] per;
        r = $urandom_range(0, 99);
        per = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
        if (r < 5) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(0, 40);
        if (r < 28)
            send(OP_ADD, clock_ms, 8'($urandom), per, 2'($urandom),
                 $urandom_range(0, 5) != 0, $urandom_range(0, 3) == 0, 1'($urandom));
        else if (r < 55)
            send(OP_TICK, clock_ms, 8'($urandom), $urandom, 2'($urandom), 1'($urandom),
                 1'($urandom), 1'($urandom));
        else if (r < 72)
            send(OP_DONE, $urandom,
                 ($urandom_range(0, 7) == 0) ? 8'($urandom) : sb.pick_id(1),
                 $urandom, 2'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        else if (r < 78)
            send(OP_SUSPEND, $urandom, sb.pick_id(0), $urandom, 2'($urandom),
                 1'($urandom), 1'($urandom), 1'($urandom));
        else if (r < 84)
            send(OP_RESUME, clock_ms, sb.pick_id(0), $urandom, 2'($urandom),
                 1'($urandom), 1'($urandom), 1'($urandom));
        else if (r < 92)
            send(OP_REMOVE, $urandom,
                 ($urandom_range(0, 5) == 0) ? 8'($urandom) : sb.pick_id(0),
                 $urandom, 2'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        else if (r < 96)
            send(OP_ESTOP, $urandom, 8'($urandom), $urandom, 2'($urandom), 1'($urandom),
                 1'($urandom), 1'($urandom));
        else
            send(OP_LEAVE, clock_ms, 8'($urandom), $urandom, 2'($urandom), 1'($urandom),
                 1'($urandom), 1'($urandom));
    endtask

    initial begin
        int waited;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_operation = OP_ADD;
        i_now_ms = '0;
        i_task_id = '0;
        i_period = '0;
        i_priority_req = '0;
        i_enable = 1'b0;
        i_single_run = 1'b0;
        i_keep_going = 1'b0;
        clock_ms = '0;
        no_gaps = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every operation, corner cases
        send(OP_TICK, 32'd0, 8'd0, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0);
        send(OP_ADD, 32'd0, 8'd0, 32'd0, 2'd3, 1'b1, 1'b0, 1'b0);
        send(OP_ADD, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 2'd0, 1'b1, 1'b1, 1'b1);
        send(OP_ADD, 32'd5, 8'd0, 32'd10, 2'd1, 1'b1, 1'b1, 1'b0);
        send(OP_ADD, 32'd5, 8'd0, 32'd3, 2'd2, 1'b0, 1'b0, 1'b0);
        send(OP_TICK, 32'd20, 8'd0, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0);
        send(OP_DONE, 32'd0, 8'd1, 32'd0, 2'd0, 1'b0, 1'b0, 1'b1);
        send(OP_DONE, 32'd0, 8'd3, 32'd0, 2'd0, 1'b0, 1'b0, 1'b1);
        send(OP_DONE, 32'd0, 8'd1, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0);
        send(OP_REMOVE, 32'd0, 8'd0, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0);
        send(OP_SUSPEND, 32'd0, 8'd2, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0);
        send(OP_SUSPEND, 32'd0, 8'd2, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0);
        send(OP_RESUME, 32'd30, 8'd2, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0);
        send(OP_RESUME, 32'd30, 8'd2, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0);
        send(OP_LEAVE, 32'd40, 8'd0, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0);
        send(OP_ESTOP, 32'd0, 8'd0, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0);
        send(OP_ESTOP, 32'd0, 8'd0, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0);
        send(OP_TICK, 32'hFFFF_FFFF, 8'd0, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0);
        send(OP_DONE, 32'd0, 8'd4, 32'd0, 2'd0, 1'b0, 1'b0, 1'b1);
        send(OP_LEAVE, 32'd50, 8'd0, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0);
        send(OP_REMOVE, 32'd0, 8'd2, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0);
        send(OP_REMOVE, 32'd0, 8'd2, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0);
        drain();

        // fill, overflow, a tick with every new slot due, then one more tick
        no_gaps = 1'b1;
        for (int k = 0; k < 15; k++)
            send(OP_ADD, 32'd100, 8'd0, 32'd0, k[1:0], 1'b1, 1'b0, 1'b0);
        send(OP_TICK, 32'hFFFF_FFFF, 8'd0, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0);
        send(OP_TICK, 32'hFFFF_FFFF, 8'd0, 32'd0, 2'd0, 1'b0, 1'b0, 1'b0);
        no_gaps = 1'b0;
        drain();
        for (int k = 0; k < SLOTS; k++)
            send(OP_REMOVE, 32'd0, sb.pick_id(0), 32'd0, 2'd0, 1'b0, 1'b0, 1'b0);
        clock_ms = 32'd200;

        for (int k = 0; k < 215; k++) begin
            if (k % 60 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            if (k == 110) drain();
            random_item();
        end
        start <= 1'b0;

        waited = 0;
        while (sb.pending.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("periodic_task_dispatcher regression: pass");
        end else begin
            $display("periodic_task_dispatcher regression: fail");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/ptd_pkg.sv
rtl/core/ptd_front.sv
rtl/core/ptd_back.sv
rtl/core/periodic_task_dispatcher.sv
tb/tb_periodic_task_dispatcher.sv
